/* hdl/mi4_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mi4_pkg;

    localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QMin = 32'sh8000_0000;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } sat_t;

    // Hand-over from loader to sequencer: a full matrix waits in bank 'bank'
    typedef struct packed {
        logic pending;
        logic bank;
    } job_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RA, S_RB, S_RC, S_M1, S_R1, S_M2, S_R2,
        S_COF, S_DA, S_DM, S_DR, S_DS, S_EL, S_DW, S_FIN
    } back_state_t;

    function automatic sat_t sat64(input logic signed [63:0] v);
        sat_t r;
        r.ovf = !((&v[63:31]) || !(|v[63:31]));
        if (r.ovf)
        begin
            r.val = v[63] ? QMin : QMax;
        end
        else
        begin
            r.val = v[31:0];
        end
        return r;
    endfunction

    // Q16.16 product rescale: round to nearest, ties up, then clamp
    function automatic sat_t round_sat(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + 64'sd32768) >>> 16;
        return sat64(s);
    endfunction

    // Position in the full matrix of place n of a 3x3 minor that drops 'skip'
    function automatic logic [1:0] skip_idx(input logic [1:0] skip, input logic [1:0] n);
        return (n < skip) ? n : n + 2'd1;
    endfunction

    // Column of minor row n used by term t of the 3x3 expansion
    function automatic logic [1:0] term_col(input logic [2:0] t, input logic [1:0] n);
        logic [5:0] cols;
        case (t)
            3'd0:    cols = {2'd2, 2'd1, 2'd0};
            3'd1:    cols = {2'd0, 2'd2, 2'd1};
            3'd2:    cols = {2'd1, 2'd0, 2'd2};
            3'd3:    cols = {2'd1, 2'd2, 2'd0};
            3'd4:    cols = {2'd2, 2'd0, 2'd1};
            3'd5:    cols = {2'd0, 2'd1, 2'd2};
            default: cols = 6'd0;
        endcase
        case (n)
            2'd0:    return cols[1:0];
            2'd1:    return cols[3:2];
            default: return cols[5:4];
        endcase
    endfunction

endpackage
`default_nettype wire

/* hdl/mi4_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module mi4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hdl/mi4_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module mi4_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [31:0]   elem_value,
    output logic               busy,
    output logic               wr_en,
    output logic [4:0]         wr_addr,
    output logic [31:0]        wr_data,
    output mi4_pkg::job_t      job,
    input  wire logic          pop
);
    import mi4_pkg::*;

    logic [3:0] cnt_reg, cnt_next;
    logic       wbank_reg, wbank_next;
    logic       rbank_reg, rbank_next;
    logic [1:0] occ_reg, occ_next;
    logic       accept, push;

    // both banks full: the next one to load is still owed to the sequencer
    assign busy    = (occ_reg == 2'd2);
    assign accept  = start && !busy;
    assign push    = accept && (cnt_reg == 4'd15);
    assign wr_en   = accept;
    assign wr_addr = {wbank_reg, cnt_reg};
    assign wr_data = elem_value;
    assign job.pending = (occ_reg != 2'd0);
    assign job.bank    = rbank_reg;

    always_comb
    begin
        cnt_next   = accept ? cnt_reg + 4'd1 : cnt_reg;
        wbank_next = push ? !wbank_reg : wbank_reg;
        rbank_next = pop ? !rbank_reg : rbank_reg;
        case ({push, pop})
            2'b10:   occ_next = occ_reg + 2'd1;
            2'b01:   occ_next = occ_reg - 2'd1;
            default: occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            wbank_reg <= 1'b0;
            rbank_reg <= 1'b0;
            occ_reg   <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            wbank_reg <= wbank_next;
            rbank_reg <= rbank_next;
            occ_reg   <= occ_next;
        end
    end
endmodule
`default_nettype wire

/* hdl/mi4_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module mi4_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic signed [31:0] den,
    output logic                    done,
    output logic signed [31:0]      quo,
    output logic                    ovf
);
    import mi4_pkg::*;

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [47:0] qd_reg, qd_next;
    logic [31:0] dv_reg, dv_next;
    logic        neg_reg, neg_next;
    logic [31:0] num_mag, den_mag;
    logic [32:0] trial, diff;
    logic        ge;

    assign num_mag = num[31] ? 32'(-num) : 32'(num);
    assign den_mag = den[31] ? 32'(-den) : 32'(den);
    assign trial   = {rem_reg, qd_reg[47]};
    assign diff    = trial - {1'b0, dv_reg};
    assign ge      = !diff[32];

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        qd_next   = qd_reg;
        dv_next   = dv_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 6'd47;
            rem_next = '0;
            qd_next  = {num_mag, 16'd0};
            dv_next  = den_mag;
            neg_next = num[31] ^ den[31];
        end
        else if (run_reg)
        begin
            // one quotient bit a cycle, restoring
            rem_next = ge ? diff[31:0] : trial[31:0];
            qd_next  = {qd_reg[46:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            ovf = (qd_reg > 48'h0000_8000_0000);
            quo = ovf ? QMin : 32'(-qd_reg[31:0]);
        end
        else
        begin
            ovf = (qd_reg > 48'h0000_7FFF_FFFF);
            quo = ovf ? QMax : qd_reg[31:0];
        end
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        qd_reg  <= qd_next;
        dv_reg  <= dv_next;
        neg_reg <= neg_next;
    end
endmodule
`default_nettype wire

/* hdl/mi4_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module mi4_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mi4_pkg::job_t job,
    output logic               pop,
    output logic [4:0]         rd_addr,
    input  wire logic [31:0]   rd_data,
    output logic               valid,
    output logic signed [31:0] inv_value,
    output logic signed [31:0] det_value,
    output logic               singular,
    output logic               overflow,
    output logic               last
);
    import mi4_pkg::*;

    back_state_t        state_reg, state_next;
    logic [3:0]         k_reg, k_next;
    logic [2:0]         t_reg, t_next;
    logic signed [31:0] opa_reg, opa_next, opb_reg, opb_next, opc_reg, opc_next;
    logic signed [31:0] q1_reg, q1_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [35:0] acc_reg, acc_next;
    logic               flag_reg, flag_next;
    logic signed [31:0] adj_reg [16];
    logic signed [31:0] adj_next [16];
    logic [15:0]        eflag_reg, eflag_next;
    logic signed [31:0] det_reg, det_next;
    logic               dflag_reg, dflag_next;
    logic               valid_reg, valid_next, last_reg, last_next;
    logic signed [31:0] inv_reg, inv_next;
    logic               ovf_reg, ovf_next;

    logic signed [31:0] rd_s, mula, mulb;
    logic signed [63:0] mul;
    logic signed [35:0] v36, cof_sum;
    logic [1:0]         ci, rj, n_sel;
    logic [3:0]         col0;
    sat_t               rs, cof_sat, det_sat;
    logic               div_start, div_done, div_ovf;
    logic signed [31:0] div_quo;

    assign rd_s    = rd_data;
    assign ci      = k_reg[3:2];
    assign rj      = k_reg[1:0];
    assign col0    = {k_reg[1:0], 2'b00};
    assign rs      = round_sat(prod_reg);
    assign v36     = 36'(rs.val);
    assign cof_sum = (ci[0] ^ rj[0]) ? -acc_reg : acc_reg;
    assign cof_sat = sat64(64'(cof_sum));
    assign det_sat = sat64(64'(acc_reg));
    assign mul     = 64'(mula) * 64'(mulb);

    always_comb
    begin
        case (state_reg)
            S_RB:    n_sel = 2'd1;
            S_RC:    n_sel = 2'd2;
            default: n_sel = 2'd0;
        endcase
        if (state_reg == S_DA)
        begin
            rd_addr = {job.bank, 2'b00, k_reg[1:0]};
        end
        else
        begin
            rd_addr = {job.bank, skip_idx(rj, n_sel), skip_idx(ci, term_col(t_reg, n_sel))};
        end
        case (state_reg)
            S_M1:
            begin
                mula = opa_reg;
                mulb = opb_reg;
            end
            S_M2:
            begin
                mula = q1_reg;
                mulb = opc_reg;
            end
            default:
            begin
                mula = rd_s;
                mulb = adj_reg[col0];
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        t_next     = t_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        opc_next   = opc_reg;
        q1_next    = q1_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        flag_next  = flag_reg;
        adj_next   = adj_reg;
        eflag_next = eflag_reg;
        det_next   = det_reg;
        dflag_next = dflag_reg;
        valid_next = 1'b0;
        last_next  = 1'b0;
        inv_next   = inv_reg;
        ovf_next   = ovf_reg;
        div_start  = 1'b0;
        pop        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (job.pending)
                begin
                    k_next     = '0;
                    t_next     = '0;
                    acc_next   = '0;
                    flag_next  = 1'b0;
                    dflag_next = 1'b0;
                    state_next = S_RA;
                end
            end
            S_RA: state_next = S_RB;
            S_RB:
            begin
                opa_next   = rd_s;
                state_next = S_RC;
            end
            S_RC:
            begin
                opb_next   = rd_s;
                state_next = S_M1;
            end
            S_M1:
            begin
                opc_next   = rd_s;
                prod_next  = mul;
                state_next = S_R1;
            end
            S_R1:
            begin
                q1_next    = rs.val;
                flag_next  = flag_reg | rs.ovf;
                state_next = S_M2;
            end
            S_M2:
            begin
                prod_next  = mul;
                state_next = S_R2;
            end
            S_R2:
            begin
                acc_next  = (t_reg >= 3'd3) ? acc_reg - v36 : acc_reg + v36;
                flag_next = flag_reg | rs.ovf;
                if (t_reg == 3'd5)
                begin
                    state_next = S_COF;
                end
                else
                begin
                    t_next     = t_reg + 3'd1;
                    state_next = S_RA;
                end
            end
            S_COF:
            begin
                adj_next[k_reg]   = cof_sat.val;
                eflag_next[k_reg] = flag_reg | cof_sat.ovf;
                acc_next  = '0;
                flag_next = 1'b0;
                t_next    = '0;
                k_next    = k_reg + 4'd1;
                state_next = (k_reg == 4'd15) ? S_DA : S_RA;
            end
            S_DA: state_next = S_DM;
            S_DM:
            begin
                prod_next  = mul;
                state_next = S_DR;
            end
            S_DR:
            begin
                acc_next   = acc_reg + v36;
                dflag_next = dflag_reg | rs.ovf | eflag_reg[col0];
                if (k_reg[1:0] == 2'd3)
                begin
                    k_next     = '0;
                    state_next = S_DS;
                end
                else
                begin
                    k_next     = k_reg + 4'd1;
                    state_next = S_DA;
                end
            end
            S_DS:
            begin
                det_next   = det_sat.val;
                dflag_next = dflag_reg | det_sat.ovf;
                acc_next   = '0;
                state_next = S_EL;
            end
            S_EL:
            begin
                if (det_reg == 32'sd0)
                begin
                    valid_next = 1'b1;
                    inv_next   = '0;
                    ovf_next   = dflag_reg;
                    last_next  = (k_reg == 4'd15);
                    k_next     = k_reg + 4'd1;
                    state_next = (k_reg == 4'd15) ? S_FIN : S_EL;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DW;
                end
            end
            S_DW:
            begin
                if (div_done)
                begin
                    valid_next = 1'b1;
                    inv_next   = div_quo;
                    ovf_next   = div_ovf | eflag_reg[k_reg] | dflag_reg;
                    last_next  = (k_reg == 4'd15);
                    k_next     = k_reg + 4'd1;
                    state_next = (k_reg == 4'd15) ? S_FIN : S_EL;
                end
            end
            S_FIN:
            begin
                // release the bank to the loader
                pop        = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    mi4_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (adj_reg[k_reg]),
        .den   (det_reg),
        .done  (div_done),
        .quo   (div_quo),
        .ovf   (div_ovf)
    );

    assign valid     = valid_reg;
    assign last      = last_reg;
    assign inv_value = inv_reg;
    assign overflow  = ovf_reg;
    assign det_value = det_reg;
    assign singular  = (det_reg == 32'sd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            t_reg     <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            t_reg     <= t_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opa_reg   <= opa_next;
        opb_reg   <= opb_next;
        opc_reg   <= opc_next;
        q1_reg    <= q1_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        flag_reg  <= flag_next;
        adj_reg   <= adj_next;
        eflag_reg <= eflag_next;
        det_reg   <= det_next;
        dflag_reg <= dflag_next;
        inv_reg   <= inv_next;
        ovf_reg   <= ovf_next;
    end
endmodule
`default_nettype wire

/* hdl/matrix_inverse_4x4.sv */
`timescale 1ns / 1ps
`default_nettype none
// 4x4 matrix inverse by adjugate, signed Q16.16. Elements go in row-major, one per
// cycle while busy is low; the matrix store has two banks, so a second matrix may load
// while the first is worked on, and busy rises only when both banks hold full matrices.
// Sixteen results then leave row-major, each valid for one cycle with det_value,
// singular, overflow and last; the receiver cannot stall them. Work per matrix is the
// sixteen cofactors (six triple products each, one shared 32x32 multiplier fed from a
// single-read-port store), then the determinant, then one division per element in
// the bit-serial 48-bit divider (none when singular).
module matrix_inverse_4x4 (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] elem_value,
    output logic                    valid,
    output logic signed [31:0]      inv_value,
    output logic signed [31:0]      det_value,
    output logic                    singular,
    output logic                    overflow,
    output logic                    last
);
    import mi4_pkg::*;

    logic        wr_en, pop;
    logic [4:0]  wr_addr, rd_addr;
    logic [31:0] wr_data, rd_data;
    job_t        job;

    mi4_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .elem_value (elem_value),
        .busy       (busy),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .job        (job),
        .pop        (pop)
    );

    mi4_ram #(
        .WIDTH (32),
        .DEPTH (32)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    mi4_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .pop       (pop),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .valid     (valid),
        .inv_value (inv_value),
        .det_value (det_value),
        .singular  (singular),
        .overflow  (overflow),
        .last      (last)
    );
endmodule
`default_nettype wire

/* hdl/mi4_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module mi4_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               valid,
    input wire logic signed [31:0] inv_value,
    input wire logic signed [31:0] det_value,
    input wire logic               singular,
    input wire logic               last
);
    // a singular matrix gives zero elements
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && singular |-> inv_value == 32'sd0)
        else $error("singular transaction with non-zero element");

    a_sing_det: assert property (@(posedge clk) disable iff (!rst_n)
        valid && singular |-> det_value == 32'sd0)
        else $error("singular flagged with non-zero determinant");

    // determinant holds across results of one matrix
    a_det_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && $past(valid) && !$past(last) |-> $stable(det_value))
        else $error("determinant changed within a matrix");

    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> valid)
        else $error("last without a transaction");
endmodule

bind matrix_inverse_4x4 mi4_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid     (valid),
    .inv_value (inv_value),
    .det_value (det_value),
    .singular  (singular),
    .last      (last)
);
`default_nettype wire

/* bench/matrix_inverse_4x4_checker.sv */
`timescale 1ns / 1ps
module matrix_inverse_4x4_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [31:0] elem_value,
    input  logic               valid,
    input  logic signed [31:0] inv_value,
    input  logic signed [31:0] det_value,
    input  logic               singular,
    input  logic               overflow,
    input  logic               last,
    output int                 errors,
    output int                 pending
);

    typedef struct {
        logic signed [31:0] inv;
        logic signed [31:0] det;
        bit                 sing;
        bit                 ovf;
        bit                 lst;
    } inv_entry_t;

    logic signed [31:0] mat_elems [16];
    int                 fill_count;
    inv_entry_t         inverse_q [$];

    function automatic logic signed [31:0] clamp32(input longint v, inout bit f);
        if (v > longint'(32'sh7FFF_FFFF))
        begin
            f = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -longint'(32'sh7FFF_FFFF) - 1)
        begin
            f = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Q16.16 product: round half up by adding half an LSB, then floor shift
    function automatic logic signed [31:0] qprod(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 inout bit f);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd32768;
        return clamp32(p >>> 16, f);
    endfunction

    function automatic longint minor_det(input int skip_r, input int skip_c, inout bit f);
        logic signed [31:0] m [3][3];
        int rr;
        int cc;
        rr = 0;
        for (int r = 0; r < 4; r++)
        begin
            if (r != skip_r)
            begin
                cc = 0;
                for (int c = 0; c < 4; c++)
                begin
                    if (c != skip_c)
                    begin
                        m[rr][cc] = mat_elems[r * 4 + c];
                        cc++;
                    end
                end
                rr++;
            end
        end
        return longint'(qprod(qprod(m[0][0], m[1][1], f), m[2][2], f))
             + longint'(qprod(qprod(m[0][1], m[1][2], f), m[2][0], f))
             + longint'(qprod(qprod(m[0][2], m[1][0], f), m[2][1], f))
             - longint'(qprod(qprod(m[0][0], m[1][2], f), m[2][1], f))
             - longint'(qprod(qprod(m[0][1], m[1][0], f), m[2][2], f))
             - longint'(qprod(qprod(m[0][2], m[1][1], f), m[2][0], f));
    endfunction

    task automatic predict_inverse();
        logic signed [31:0] adj [16];
        bit                 adj_ovf [16];
        bit                 det_ovf;
        bit                 f;
        longint             s;
        longint             det_sum;
        logic signed [31:0] det;
        inv_entry_t         e;
        det_ovf = 1'b0;
        det_sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                f = 1'b0;
                // transposed minor: drop row j and column i
                s = minor_det(j, i, f);
                if (((i + j) & 1) != 0)
                begin
                    s = -s;
                end
                adj[i * 4 + j] = clamp32(s, f);
                adj_ovf[i * 4 + j] = f;
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            if (adj_ovf[i * 4])
            begin
                det_ovf = 1'b1;
            end
            det_sum += longint'(qprod(mat_elems[i], adj[i * 4], det_ovf));
        end
        det = clamp32(det_sum, det_ovf);
        for (int k = 0; k < 16; k++)
        begin
            f = 1'b0;
            e.inv = '0;
            if (det != 0)
            begin
                e.inv = clamp32((longint'(adj[k]) * 65536) / longint'(det), f);
                f = f || adj_ovf[k];
            end
            e.det = det;
            e.sing = (det == 0);
            e.ovf = f || det_ovf;
            e.lst = (k == 15);
            inverse_q.push_back(e);
        end
    endtask

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count = 0;
            errors = 0;
            inverse_q.delete();
        end
        else
        begin
            if (valid)
            begin
                if (inverse_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected: inv %0d det %0d",
                             $time, inv_value, det_value);
                    errors++;
                end
                else
                begin
                    inv_entry_t e;
                    e = inverse_q.pop_front();
                    if (inv_value !== e.inv)
                    begin
                        $display("%0t: inv_value expected %0d actual %0d",
                                 $time, e.inv, inv_value);
                        errors++;
                    end
                    if (det_value !== e.det)
                    begin
                        $display("%0t: det_value expected %0d actual %0d",
                                 $time, e.det, det_value);
                        errors++;
                    end
                    if (singular !== e.sing)
                    begin
                        $display("%0t: singular expected %0b actual %0b",
                                 $time, e.sing, singular);
                        errors++;
                    end
                    if (overflow !== e.ovf)
                    begin
                        $display("%0t: overflow expected %0b actual %0b",
                                 $time, e.ovf, overflow);
                        errors++;
                    end
                    if (last !== e.lst)
                    begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, e.lst, last);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                mat_elems[fill_count] = elem_value;
                if (fill_count == 15)
                begin
                    fill_count = 0;
                    predict_inverse();
                end
                else
                begin
                    fill_count++;
                end
            end
        end
        pending = inverse_q.size();
    end

endmodule

/* bench/matrix_inverse_4x4_tb.sv */
`timescale 1ns / 1ps
module matrix_inverse_4x4_tb;

    localparam int StallLimit = 20000;
    localparam int NumMatrices = 29;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] elem_value;
    logic               valid;
    logic signed [31:0] inv_value;
    logic signed [31:0] det_value;
    logic               singular;
    logic               overflow;
    logic               last;
    int                 errors;
    int                 pending;
    int                 idle_cycles;
    bit                 allow_gaps;

    matrix_inverse_4x4 i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .elem_value (elem_value),
        .valid      (valid),
        .inv_value  (inv_value),
        .det_value  (det_value),
        .singular   (singular),
        .overflow   (overflow),
        .last       (last)
    );

    matrix_inverse_4x4_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .elem_value (elem_value),
        .valid      (valid),
        .inv_value  (inv_value),
        .det_value  (det_value),
        .singular   (singular),
        .overflow   (overflow),
        .last       (last),
        .errors     (errors),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || valid || (start && !busy))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= StallLimit)
        begin
            $display("matrix_inverse_4x4_tb: errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction
    task automatic send_elem(input logic signed [31:0] v);
        bit taken;
        if (allow_gaps && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        start <= 1'b1;
        elem_value <= v;
        #0;
        do
        begin
            taken = !busy;
            @(negedge clk);
        end
        while (!taken);
    endtask

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 6))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            3: return 32'sh0000_0001;
            4: return 32'shFFFF_FFFF;
            5: return 32'sh0001_0000;
            default: return 32'shFFFF_0000;
        endcase
    endfunction

    task automatic send_matrix(input int kind);
        logic signed [31:0] m [16];
        for (int k = 0; k < 16; k++)
        begin
            case (kind)
                0: m[k] = $urandom;
                1: m[k] = int'($urandom_range(0, 1048575)) - 524288;
                2: m[k] = (int'($urandom_range(0, 16)) - 8) <<< 16;
                3: m[k] = pick_extreme();
                4: m[k] = int'($urandom_range(0, 16)) - 8;
                default: m[k] = (k % 5 == 0) ? 32'sh0001_0000 : 32'sh0;
            endcase
        end
        // integer-valued rows with a repeated row give an exactly zero determinant
        if (kind == 2 && $urandom_range(0, 1) == 1)
        begin
            for (int c = 0; c < 4; c++)
            begin
                m[12 + c] = m[4 + c];
            end
        end
        for (int k = 0; k < 16; k++)
        begin
            send_elem(m[k]);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        elem_value = '0;
        idle_cycles = 0;
        allow_gaps = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // identity, then a matrix of the field extremes
        send_matrix(5);
        for (int k = 0; k < 16; k++)
        begin
            send_elem((k % 2 == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
        end

        allow_gaps = 1'b1;
        for (int n = 0; n < NumMatrices - 2; n++)
        begin
            if (n == 10)
            begin
                // hold off until the block has drained
                start <= 1'b0;
                @(negedge clk);
                while (pending != 0)
                begin
                    @(negedge clk);
                end
            end
            if (n >= NumMatrices - 7)
            begin
                allow_gaps = 1'b0;
            end
            case ($urandom_range(0, 9))
                0, 1: send_matrix(0);
                2, 3, 4: send_matrix(1);
                5, 6: send_matrix(2);
                7, 8: send_matrix(3);
                default: send_matrix(4);
            endcase
        end
        start <= 1'b0;

        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (200) @(negedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("matrix_inverse_4x4_tb: clean");
        end
        else
        begin
            $display("matrix_inverse_4x4_tb: errors");
        end
        $finish;
    end

endmodule
